@@ rtl/assert_macros.svh @@
// assertion macros for the port-level checker file
// each macro expects clk and rst_n in scope of the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold on every clock outside reset
`define CHK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/blc_pkg.sv @@
// types, constants and helpers for the bitrate ladder controller
// no dependencies; imported by the core and its checker
package blc_pkg;

    localparam int MAX_RUNGS_DEF        = 8;
    localparam int TICKS_PER_SECOND_DEF = 60;

    // frame budget in microseconds is BUDGET_NUM / fps
    localparam int BUDGET_NUM    = 1000000;
    localparam int DIV_W         = 20;
    localparam int FPS_W         = 8;
    localparam int FPS_MIN       = 24;
    localparam int FPS_MAX       = 144;
    localparam int FPS_RESET     = 60;
    localparam int BUDGET_W      = 16;
    localparam int BUDGET_RESET  = BUDGET_NUM / FPS_RESET;

    localparam int PCT_MIN       = 1;
    localparam int PCT_MAX       = 90;
    localparam int PCT_RESET     = 20;
    localparam int PCT_BASE      = 100;
    localparam int HEALTHY_PCT   = 80;
    localparam int WIN_MIN       = 1;
    localparam int WIN_MAX       = 120;
    localparam int WIN_RESET     = 10;
    localparam int HOLD_MIN      = 1;
    localparam int HOLD_MAX      = 600;
    localparam int HOLD_RESET    = 10;
    localparam int COUNT_RESET   = 7;
    localparam int DROP_LIMIT    = 2;
    localparam int EWMA_SHIFT    = 3;

    localparam logic [63:0] RUNGS_FIRST_RESET  = 64'h36B0_4E20_7530_AFC8;
    localparam logic [63:0] RUNGS_SECOND_RESET = 64'h0000_0FA0_1770_2710;

    localparam int LIM_W    = 24;
    localparam int SCALED_W = 27;
    localparam int AVG_W    = 28;

    // register indexes
    localparam logic [2:0] REG_OVERLOAD_PCT = 3'd0;
    localparam logic [2:0] REG_OVERLOAD_WIN = 3'd1;
    localparam logic [2:0] REG_HOLD_SECONDS = 3'd2;
    localparam logic [2:0] REG_FRAME_RATE   = 3'd3;
    localparam logic [2:0] REG_RUNG_COUNT   = 3'd4;
    localparam logic [2:0] REG_RUNGS_FIRST  = 3'd5;
    localparam logic [2:0] REG_RUNGS_SECOND = 3'd6;

    // step directions
    localparam logic [1:0] DIR_STAY = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;

    // causes
    localparam logic [2:0] CAUSE_UNCONFIGURED  = 3'd0;
    localparam logic [2:0] CAUSE_OVERLOAD_STEP = 3'd1;
    localparam logic [2:0] CAUSE_OVERLOAD_WAIT = 3'd2;
    localparam logic [2:0] CAUSE_DROP_STEP     = 3'd3;
    localparam logic [2:0] CAUSE_DROP_WAIT     = 3'd4;
    localparam logic [2:0] CAUSE_UP_STEP       = 3'd5;
    localparam logic [2:0] CAUSE_HEALTHY_WAIT  = 3'd6;

    typedef struct packed {
        logic [15:0] current_rate;
        logic [19:0] encode_time;
        logic        frame_dropped;
    } tick_t;

    typedef struct packed {
        logic [15:0] new_rate;
        logic [15:0] old_rate;
        logic        rate_changed;
        logic [1:0]  step_direction;
        logic [2:0]  cause_code;
        logic [15:0] counter_shown;
        logic [27:0] smoothed_time;
        logic [2:0]  rung_now;
    } result_t;

    function automatic logic [15:0] clamp16(
        input logic [15:0] v,
        input logic [15:0] lo,
        input logic [15:0] hi
    );
        logic [15:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

@@ rtl/bitrate_ladder_controller_core.sv @@
// bitrate ladder controller: per-frame rung selection with ewma and streak counters
// depends on blc_pkg
//
// usage
//   tick channel (tick_valid / tick_stall / tick_data): one request per video frame
//   result channel (result_valid / result_stall / result_data): one result per request,
//   in order
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   to be given by the user only while no request is in flight; the core does not enforce it
// a request accepted into the input register is decided from there into the result register
// throughput: one request per cycle while no divide runs and the receiver does not
//   stall, set by the single input register and the single result register; the
//   whole decision is one pass of compares, one ewma add and one rung mux
// a frame_rate write starts a serial divide for the frame budget;
//   tick_stall is high and cfg_ready low during it
// reset restores every configuration register to its documented value and clears the
//   rung index, the average and all counters; the budget is preloaded, so no divide runs
// when the receiver stalls, the result register holds, and one more request
//   may sit in the input register before tick_stall rises
module bitrate_ladder_controller_core
    import blc_pkg::*;
#(
    parameter int MAX_RUNGS        = MAX_RUNGS_DEF,
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        tick_valid,
    output logic        tick_stall,
    input  tick_t       tick_data,

    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result_data,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NEEDED_W   = $clog2(HOLD_MAX * TICKS_PER_SECOND + 1);
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    // configuration
    logic [6:0]          pct_reg;
    logic [6:0]          win_reg;
    logic [9:0]          hold_reg;
    logic [3:0]          count_reg;
    logic [63:0]         rungs_first_reg;
    logic [63:0]         rungs_second_reg;
    logic [BUDGET_W-1:0] budget_reg;

    // derived limits
    logic [LIM_W-1:0]    over_lim_reg;
    logic [LIM_W-1:0]    up_lim_reg;
    logic [NEEDED_W-1:0] needed_reg;
    logic [LIM_W-1:0]    over_lim_next;
    logic [LIM_W-1:0]    up_lim_next;
    logic [NEEDED_W-1:0] needed_next;

    // budget divider
    logic                 div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [FPS_W-1:0]     div_rem_reg;
    logic [DIV_W-1:0]     div_quo_reg;
    logic [FPS_W-1:0]     div_den_reg;
    logic [FPS_W:0]       div_trial;
    logic                 div_ge;
    logic [FPS_W-1:0]     div_rem_next;
    logic [DIV_W-1:0]     div_quo_next;

    // pipeline
    logic    tick_valid_reg;
    tick_t   tick_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    out_free;
    logic    advance;
    logic    tick_accept;
    logic    cfg_write;

    // ladder state
    logic [2:0]       rung_reg;
    logic [AVG_W-1:0] avg_reg;
    logic [7:0]       over_streak_reg;
    logic [7:0]       drop_streak_reg;
    logic [15:0]      healthy_reg;
    logic [2:0]       rung_next;
    logic [AVG_W-1:0] avg_next;
    logic [7:0]       over_streak_next;
    logic [7:0]       drop_streak_next;
    logic [15:0]      healthy_next;

    // step datapath
    logic [3:0]          rungs_used;
    logic [6:0]          win_clamped;
    logic                configured;
    logic                can_down;
    logic [SCALED_W-1:0] scaled;
    logic [AVG_W-1:0]    sample_q8;
    logic [AVG_W:0]      avg_fall;
    logic [7:0]          over_inc;
    logic [7:0]          drop_inc;
    logic [15:0]         healthy_inc;
    logic                changed;
    logic [1:0]          dir;
    logic [2:0]          cause;
    logic [15:0]         shown;
    logic [127:0]        rungs_all;

    assign cfg_write    = cfg_valid && cfg_ready;
    assign cfg_ready    = !div_busy_reg;
    assign out_free     = !result_valid_reg || !result_stall;
    assign advance      = tick_valid_reg && out_free;
    assign tick_stall   = div_busy_reg || (tick_valid_reg && !out_free);
    assign tick_accept  = tick_valid && !tick_stall;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // derived limits, refreshed every cycle
    always_comb
    begin
        over_lim_next = LIM_W'(clamp16(16'(pct_reg), 16'(PCT_MIN), 16'(PCT_MAX)) + 16'(PCT_BASE))
                        * LIM_W'(budget_reg);
        up_lim_next   = LIM_W'(HEALTHY_PCT) * LIM_W'(budget_reg);
        needed_next   = NEEDED_W'(clamp16(16'(hold_reg), 16'(HOLD_MIN), 16'(HOLD_MAX)))
                        * NEEDED_W'(TICKS_PER_SECOND);
    end

    // one restoring divide step per cycle
    always_comb
    begin
        div_trial    = {div_rem_reg, div_quo_reg[DIV_W-1]};
        div_ge       = div_trial >= {1'b0, div_den_reg};
        div_rem_next = div_ge ? FPS_W'(div_trial - {1'b0, div_den_reg}) : div_trial[FPS_W-1:0];
        div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};
    end

    // decision for the request in the input register
    always_comb
    begin
        rungs_used  = (count_reg > 4'(MAX_RUNGS)) ? 4'(MAX_RUNGS) : count_reg;
        win_clamped = 7'(clamp16(16'(win_reg), 16'(WIN_MIN), 16'(WIN_MAX)));
        configured  = (tick_reg.current_rate != 16'd0) && (rungs_used != 4'd0);
        can_down    = ({1'b0, rung_reg} + 4'd1) < rungs_used;
        scaled      = SCALED_W'(tick_reg.encode_time) * SCALED_W'(PCT_BASE);
        sample_q8   = {tick_reg.encode_time, 8'd0};
        avg_fall    = {1'b0, avg_reg} - {1'b0, sample_q8} + (AVG_W+1)'(7);
        over_inc    = (over_streak_reg == 8'hFF) ? over_streak_reg : over_streak_reg + 8'd1;
        drop_inc    = (drop_streak_reg == 8'hFF) ? drop_streak_reg : drop_streak_reg + 8'd1;
        healthy_inc = (healthy_reg == 16'hFFFF) ? healthy_reg : healthy_reg + 16'd1;
        rungs_all   = {rungs_second_reg, rungs_first_reg};

        rung_next        = rung_reg;
        avg_next         = avg_reg;
        over_streak_next = over_streak_reg;
        drop_streak_next = drop_streak_reg;
        healthy_next     = healthy_reg;
        changed          = 1'b0;
        dir              = DIR_STAY;
        cause            = CAUSE_UNCONFIGURED;
        shown            = 16'd0;

        if (configured)
        begin
            if (avg_reg == '0)
                avg_next = sample_q8;
            else if (sample_q8 >= avg_reg)
                avg_next = avg_reg + ((sample_q8 - avg_reg) >> EWMA_SHIFT);
            else
                avg_next = avg_reg - AVG_W'(avg_fall >> EWMA_SHIFT);

            priority if (scaled >= SCALED_W'(over_lim_reg))
            begin
                over_streak_next = over_inc;
                shown            = 16'(over_inc);
                if (over_inc >= {1'b0, win_clamped} && can_down)
                begin
                    rung_next        = rung_reg + 3'd1;
                    changed          = 1'b1;
                    dir              = DIR_DOWN;
                    cause            = CAUSE_OVERLOAD_STEP;
                    over_streak_next = 8'd0;
                end
                else
                begin
                    cause = CAUSE_OVERLOAD_WAIT;
                end
            end
            else if (tick_reg.frame_dropped)
            begin
                drop_streak_next = drop_inc;
                shown            = 16'(drop_inc);
                if (drop_inc >= 8'(DROP_LIMIT) && can_down)
                begin
                    rung_next        = rung_reg + 3'd1;
                    changed          = 1'b1;
                    dir              = DIR_DOWN;
                    cause            = CAUSE_DROP_STEP;
                    drop_streak_next = 8'd0;
                    over_streak_next = 8'd0;
                end
                else
                begin
                    cause = CAUSE_DROP_WAIT;
                end
            end
            else
            begin
                over_streak_next = 8'd0;
                drop_streak_next = 8'd0;
                healthy_next     = healthy_inc;
                shown            = healthy_inc;
                if (rung_reg != 3'd0 && scaled < SCALED_W'(up_lim_reg)
                    && 32'(healthy_inc) >= 32'(needed_reg))
                begin
                    rung_next    = rung_reg - 3'd1;
                    changed      = 1'b1;
                    dir          = DIR_UP;
                    cause        = CAUSE_UP_STEP;
                    healthy_next = 16'd0;
                end
                else
                begin
                    cause = CAUSE_HEALTHY_WAIT;
                end
            end
        end

        result_next.new_rate       = changed ? rungs_all[{rung_next, 4'd0} +: 16]
                                             : tick_reg.current_rate;
        result_next.old_rate       = tick_reg.current_rate;
        result_next.rate_changed   = changed;
        result_next.step_direction = dir;
        result_next.cause_code     = cause;
        result_next.counter_shown  = shown;
        result_next.smoothed_time  = avg_next;
        result_next.rung_now       = rung_next;
    end

    // configuration, derived limits and budget divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg          <= 7'(PCT_RESET);
            win_reg          <= 7'(WIN_RESET);
            hold_reg         <= 10'(HOLD_RESET);
            count_reg        <= 4'(COUNT_RESET);
            rungs_first_reg  <= RUNGS_FIRST_RESET;
            rungs_second_reg <= RUNGS_SECOND_RESET;
            budget_reg       <= BUDGET_W'(BUDGET_RESET);
            over_lim_reg     <= LIM_W'((PCT_BASE + PCT_RESET) * BUDGET_RESET);
            up_lim_reg       <= LIM_W'(HEALTHY_PCT * BUDGET_RESET);
            needed_reg       <= NEEDED_W'(HOLD_RESET * TICKS_PER_SECOND);
            div_busy_reg     <= 1'b0;
            div_cnt_reg      <= '0;
            div_rem_reg      <= '0;
            div_quo_reg      <= '0;
            div_den_reg      <= '0;
        end
        else
        begin
            over_lim_reg <= over_lim_next;
            up_lim_reg   <= up_lim_next;
            needed_reg   <= needed_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_OVERLOAD_PCT: pct_reg <= cfg_data[6:0];
                    REG_OVERLOAD_WIN: win_reg <= cfg_data[6:0];
                    REG_HOLD_SECONDS: hold_reg <= cfg_data[9:0];
                    REG_FRAME_RATE:
                    begin
                        div_den_reg  <= FPS_W'(clamp16(16'(cfg_data[7:0]), 16'(FPS_MIN),
                                                       16'(FPS_MAX)));
                        div_rem_reg  <= '0;
                        div_quo_reg  <= DIV_W'(BUDGET_NUM);
                        div_cnt_reg  <= '0;
                        div_busy_reg <= 1'b1;
                    end
                    REG_RUNG_COUNT:   count_reg <= cfg_data[3:0];
                    REG_RUNGS_FIRST:  rungs_first_reg <= cfg_data;
                    REG_RUNGS_SECOND: rungs_second_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            else if (div_busy_reg)
            begin
                div_rem_reg <= div_rem_next;
                div_quo_reg <= div_quo_next;
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    div_busy_reg <= 1'b0;
                    budget_reg   <= div_quo_next[BUDGET_W-1:0];
                end
            end
        end
    end

    // pipeline control and ladder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            rung_reg         <= '0;
            avg_reg          <= '0;
            over_streak_reg  <= '0;
            drop_streak_reg  <= '0;
            healthy_reg      <= '0;
        end
        else
        begin
            if (tick_accept)
                tick_valid_reg <= 1'b1;
            else if (advance)
                tick_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (out_free)
                result_valid_reg <= 1'b0;

            if (cfg_write && (cfg_index == REG_RUNG_COUNT || cfg_index == REG_RUNGS_FIRST
                              || cfg_index == REG_RUNGS_SECOND))
            begin
                rung_reg <= '0;
            end
            else if (advance)
            begin
                rung_reg        <= rung_next;
                avg_reg         <= avg_next;
                over_streak_reg <= over_streak_next;
                drop_streak_reg <= drop_streak_next;
                healthy_reg     <= healthy_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick_accept)
            tick_reg <= tick_data;
        if (advance)
            result_reg <= result_next;
    end

endmodule

@@ rtl/blc_checker.sv @@
// port-level checks for the bitrate ladder controller, bound to the core
// depends on blc_pkg and assert_macros.svh
`include "assert_macros.svh"

module blc_checker
    import blc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result_data
);

    logic step_cause;

    assign step_cause = result_data.cause_code == CAUSE_OVERLOAD_STEP
                        || result_data.cause_code == CAUSE_DROP_STEP
                        || result_data.cause_code == CAUSE_UP_STEP;

    // stalled result holds
    `CHK_NEXT(a_result_hold, result_valid && result_stall,
              result_valid && $stable(result_data), "stalled result changed")

    // rate moves only with a step cause
    `CHK_IMPLY(a_change_cause, result_valid, result_data.rate_changed == step_cause,
               "rate_changed disagrees with cause")

    // no change keeps the rate and direction
    `CHK_IMPLY(a_stay_rate, result_valid && !result_data.rate_changed,
               result_data.new_rate == result_data.old_rate
               && result_data.step_direction == DIR_STAY, "rate moved without a step")

    // unconfigured ticks report nothing
    `CHK_IMPLY(a_unconfigured, result_valid && result_data.cause_code == CAUSE_UNCONFIGURED,
               result_data.counter_shown == 16'd0 && !result_data.rate_changed,
               "unconfigured tick reported a count or change")

    // up steps never leave the rung index at 7
    `CHK_IMPLY(a_up_index, result_valid && result_data.step_direction == DIR_UP,
               result_data.rung_now != 3'd7, "up step left an impossible rung")

endmodule

bind bitrate_ladder_controller_core blc_checker u_blc_checker (.*);

@@ dv/bitrate_ladder_controller_checker.sv @@
// checker for the bitrate ladder controller: watches the cfg, tick and result channels,
// predicts each result from its own copy of the registers and state, and compares in order
// depends on blc_pkg
`timescale 1ns / 1ps

module bitrate_ladder_controller_checker
    import blc_pkg::*;
#(
    parameter int MAX_RUNGS        = MAX_RUNGS_DEF,
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        tick_valid,
    input  logic        tick_stall,
    input  tick_t       tick_data,

    input  logic        result_valid,
    input  logic        result_stall,
    input  result_t     result_data,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    output int          mismatches,
    output int          decisions_due
);

    logic [6:0]  pct_reg;
    logic [6:0]  window_reg;
    logic [9:0]  hold_reg;
    logic [7:0]  fps_reg;
    logic [3:0]  count_reg;
    logic [63:0] ladder_top;
    logic [63:0] ladder_bottom;
    int unsigned frame_budget;

    logic [2:0]  rung;
    logic [27:0] avg_time;
    logic [7:0]  overload_run;
    logic [7:0]  drop_run;
    logic [15:0] healthy_run;

    result_t     pending_decisions[$];

    function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned budget_for(input logic [7:0] fps);
        return BUDGET_NUM / clamp_u(fps, FPS_MIN, FPS_MAX);
    endfunction

    function automatic logic [15:0] rung_kbps(input logic [2:0] idx);
        logic [63:0] word;
        word = (idx < 3'd4) ? ladder_top : ladder_bottom;
        return word[idx[1:0] * 16 +: 16];
    endfunction

    task automatic restore_defaults();
        pct_reg       = 7'(PCT_RESET);
        window_reg    = 7'(WIN_RESET);
        hold_reg      = 10'(HOLD_RESET);
        fps_reg       = 8'(FPS_RESET);
        count_reg     = 4'(COUNT_RESET);
        ladder_top    = RUNGS_FIRST_RESET;
        ladder_bottom = RUNGS_SECOND_RESET;
        frame_budget  = budget_for(fps_reg);
        rung          = '0;
        avg_time      = '0;
        overload_run  = '0;
        drop_run      = '0;
        healthy_run   = '0;
    endtask

    task automatic apply_write(input logic [2:0] idx, input logic [63:0] value);
        case (idx)
            REG_OVERLOAD_PCT: pct_reg = value[6:0];
            REG_OVERLOAD_WIN: window_reg = value[6:0];
            REG_HOLD_SECONDS: hold_reg = value[9:0];
            REG_FRAME_RATE:
            begin
                fps_reg      = value[7:0];
                frame_budget = budget_for(fps_reg);
            end
            REG_RUNG_COUNT:
            begin
                count_reg = value[3:0];
                rung      = '0;
            end
            REG_RUNGS_FIRST:
            begin
                ladder_top = value;
                rung       = '0;
            end
            REG_RUNGS_SECOND:
            begin
                ladder_bottom = value;
                rung          = '0;
            end
            default: ;
        endcase
    endtask

    task automatic decide_rate(input tick_t t, output result_t r);
        int unsigned     rungs_used;
        int unsigned     cur;
        int unsigned     needed;
        longint unsigned scaled;
        longint unsigned over_lim;
        logic            can_down;
        logic [31:0]     q8;
        r              = '0;
        r.new_rate     = t.current_rate;
        r.old_rate     = t.current_rate;
        r.cause_code   = CAUSE_UNCONFIGURED;
        r.step_direction = DIR_STAY;
        rungs_used     = (count_reg > MAX_RUNGS) ? MAX_RUNGS : count_reg;
        cur            = rung;
        if (t.current_rate != 0 && rungs_used != 0)
        begin
            scaled   = longint'(t.encode_time) * PCT_BASE;
            over_lim = longint'(PCT_BASE + clamp_u(pct_reg, PCT_MIN, PCT_MAX)) * frame_budget;
            can_down = (cur + 1 < rungs_used);

            // ewma, alpha 1/8, zero means no sample yet
            q8 = {4'h0, t.encode_time, 8'h00};
            if (avg_time == '0)
                avg_time = q8[27:0];
            else if (q8 >= {4'h0, avg_time})
                avg_time = 28'(avg_time + ((q8 - avg_time) >> EWMA_SHIFT));
            else
                avg_time = 28'(avg_time - ((avg_time - q8 + 7) >> EWMA_SHIFT));

            if (scaled >= over_lim)
            begin
                if (overload_run != 8'hFF)
                    overload_run++;
                r.counter_shown = 16'(overload_run);
                if (overload_run >= clamp_u(window_reg, WIN_MIN, WIN_MAX) && can_down)
                begin
                    rung             = 3'(cur + 1);
                    r.rate_changed   = 1'b1;
                    r.step_direction = DIR_DOWN;
                    r.cause_code     = CAUSE_OVERLOAD_STEP;
                    overload_run     = '0;
                end
                else
                    r.cause_code = CAUSE_OVERLOAD_WAIT;
            end
            else if (t.frame_dropped)
            begin
                if (drop_run != 8'hFF)
                    drop_run++;
                r.counter_shown = 16'(drop_run);
                if (drop_run >= DROP_LIMIT && can_down)
                begin
                    rung             = 3'(cur + 1);
                    r.rate_changed   = 1'b1;
                    r.step_direction = DIR_DOWN;
                    r.cause_code     = CAUSE_DROP_STEP;
                    drop_run         = '0;
                    overload_run     = '0;
                end
                else
                    r.cause_code = CAUSE_DROP_WAIT;
            end
            else
            begin
                needed       = clamp_u(hold_reg, HOLD_MIN, HOLD_MAX) * TICKS_PER_SECOND;
                overload_run = '0;
                drop_run     = '0;
                if (healthy_run != 16'hFFFF)
                    healthy_run++;
                r.counter_shown = healthy_run;
                if (cur > 0 && scaled < longint'(HEALTHY_PCT) * frame_budget
                    && healthy_run >= needed)
                begin
                    rung             = 3'(cur - 1);
                    r.rate_changed   = 1'b1;
                    r.step_direction = DIR_UP;
                    r.cause_code     = CAUSE_UP_STEP;
                    healthy_run      = '0;
                end
                else
                    r.cause_code = CAUSE_HEALTHY_WAIT;
            end
            if (r.rate_changed)
                r.new_rate = rung_kbps(rung);
        end
        r.smoothed_time = avg_time;
        r.rung_now      = rung;
    endtask

    task automatic note_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_decisions.size() == 0)
        begin
            $display("%0t: result with no request outstanding, got %h", $time, got);
            mismatches++;
        end
        else
        begin
            want = pending_decisions.pop_front();
            note_field("new_rate", want.new_rate, got.new_rate);
            note_field("old_rate", want.old_rate, got.old_rate);
            note_field("rate_changed", want.rate_changed, got.rate_changed);
            note_field("step_direction", want.step_direction, got.step_direction);
            note_field("cause_code", want.cause_code, got.cause_code);
            note_field("counter_shown", want.counter_shown, got.counter_shown);
            note_field("smoothed_time", want.smoothed_time, got.smoothed_time);
            note_field("rung_now", want.rung_now, got.rung_now);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t predicted;
        if (!rst_n)
        begin
            restore_defaults();
            pending_decisions.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (result_valid && !result_stall)
                check_result(result_data);
            if (tick_valid && !tick_stall)
            begin
                decide_rate(tick_data, predicted);
                pending_decisions.push_back(predicted);
            end
        end
        decisions_due = pending_decisions.size();
    end

endmodule

@@ dv/tb_bitrate_ladder_controller_core.sv @@
// testbench top for the bitrate ladder controller: clock, reset, register phases,
// directed and random tick requests, result stall pattern and the verdict
// depends on blc_pkg, bitrate_ladder_controller_core and bitrate_ladder_controller_checker
`timescale 1ns / 1ps

module tb_bitrate_ladder_controller_core;
    import blc_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         RUN_LIMIT_NS = 2000000;

    typedef enum int {
        TIME_HEALTHY,
        TIME_HEALTHY_EDGE,
        TIME_MID,
        TIME_UNDER_EDGE,
        TIME_OVER_EDGE,
        TIME_OVER,
        TIME_WILD
    } time_kind_e;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        tick_valid   = 1'b0;
    logic        tick_stall;
    tick_t       tick_data    = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result_data;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index    = '0;
    logic [63:0] cfg_data     = '0;

    int          mismatches;
    int          decisions_due;

    int          items_sent = 0;
    int          burst_left = 0;
    int          pct_use    = PCT_RESET;
    int          win_use    = WIN_RESET;
    int          hold_use   = HOLD_RESET;
    int          budget_use = BUDGET_RESET;
    int          stall_left = 0;
    int          stall_mode = 0;

    bitrate_ladder_controller_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick_data    (tick_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bitrate_ladder_controller_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .tick_data     (tick_data),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_data   (result_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .decisions_due (decisions_due)
    );

    always #4 clk = ~clk;

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0: result_stall = 1'b0;
            1: result_stall = ($urandom_range(0, 3) == 0);
            2: result_stall = ($urandom_range(0, 3) != 0);
            default: result_stall = ~result_stall;
        endcase
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("bitrate_ladder_controller_core verification failed");
        $finish;
    end

    function automatic logic [19:0] pick_time(input time_kind_e kind);
        int healthy_max;
        int over_edge;
        healthy_max = (HEALTHY_PCT * budget_use - 1) / PCT_BASE;
        over_edge   = ((PCT_BASE + pct_use) * budget_use + PCT_BASE - 1) / PCT_BASE;
        case (kind)
            TIME_HEALTHY:      return 20'($urandom_range(0, healthy_max));
            TIME_HEALTHY_EDGE: return 20'(healthy_max);
            TIME_MID:          return 20'($urandom_range(healthy_max + 1, over_edge - 1));
            TIME_UNDER_EDGE:   return 20'(over_edge - 1);
            TIME_OVER_EDGE:    return 20'(over_edge);
            TIME_OVER:         return 20'(over_edge + $urandom_range(0, budget_use));
            default:           return 20'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] live_rate();
        return 16'($urandom_range(1, 65535));
    endfunction

    task automatic send_tick(input logic [15:0] rate, input logic [19:0] enc,
                             input logic drop);
        if (burst_left == 0)
        begin
            tick_valid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        tick_data  = {rate, enc, drop};
        tick_valid = 1'b1;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_idle();
        tick_valid = 1'b0;
        while (decisions_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        int v;
        wait_idle();
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            REG_OVERLOAD_PCT:
            begin
                v       = value[6:0];
                pct_use = (v < PCT_MIN) ? PCT_MIN : ((v > PCT_MAX) ? PCT_MAX : v);
            end
            REG_OVERLOAD_WIN:
            begin
                v       = value[6:0];
                win_use = (v < WIN_MIN) ? WIN_MIN : ((v > WIN_MAX) ? WIN_MAX : v);
            end
            REG_HOLD_SECONDS:
            begin
                v        = value[9:0];
                hold_use = (v < HOLD_MIN) ? HOLD_MIN : ((v > HOLD_MAX) ? HOLD_MAX : v);
            end
            REG_FRAME_RATE:
            begin
                v          = value[7:0];
                v          = (v < FPS_MIN) ? FPS_MIN : ((v > FPS_MAX) ? FPS_MAX : v);
                budget_use = BUDGET_NUM / v;
            end
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] pct, input logic [63:0] win,
                             input logic [63:0] hold, input logic [63:0] fps,
                             input logic [63:0] count, input logic [63:0] first,
                             input logic [63:0] second);
        write_reg(REG_OVERLOAD_PCT, pct);
        write_reg(REG_OVERLOAD_WIN, win);
        write_reg(REG_HOLD_SECONDS, hold);
        write_reg(REG_FRAME_RATE, fps);
        write_reg(REG_RUNG_COUNT, count);
        write_reg(REG_RUNGS_FIRST, first);
        write_reg(REG_RUNGS_SECOND, second);
    endtask

    task automatic run_streak(input time_kind_e kind, input logic drop, input int len);
        repeat (len)
            send_tick(live_rate(), pick_time(kind), drop);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int pick;
        int len;
        int needed;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 32)
            begin
                // overload run toward a down step
                len = (win_use > 16) ? $urandom_range(1, 16) : win_use + $urandom_range(0, 2);
                repeat (len)
                    send_tick(live_rate(),
                              pick_time(($urandom_range(0, 3) == 0) ? TIME_OVER_EDGE
                                                                    : TIME_OVER),
                              1'($urandom));
            end
            else if (pick < 58)
            begin
                // dropped pair
                repeat (2)
                    send_tick(live_rate(),
                              pick_time(($urandom_range(0, 1) == 0) ? TIME_HEALTHY : TIME_MID),
                              1'b1);
            end
            else if (pick < 66)
            begin
                // healthy hold toward an up step
                needed = hold_use * TICKS_PER_SECOND_DEF;
                len    = (needed > 80) ? $urandom_range(1, 20) : needed + $urandom_range(0, 2);
                repeat (len - 1)
                    send_tick(live_rate(),
                              pick_time(($urandom_range(0, 7) == 0) ? TIME_MID : TIME_HEALTHY),
                              1'b0);
                send_tick(live_rate(),
                          pick_time(($urandom_range(0, 2) == 0) ? TIME_HEALTHY_EDGE
                                                                : TIME_HEALTHY),
                          1'b0);
            end
            else if (pick < 84)
            begin
                repeat ($urandom_range(1, 6))
                    send_tick(($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom),
                              pick_time(time_kind_e'($urandom_range(0, 6))),
                              1'($urandom));
            end
            else
            begin
                // interrupted streaks
                if ($urandom_range(0, 1) == 0)
                    run_streak(TIME_OVER, 1'b0, $urandom_range(1, (win_use > 16) ? 16 : win_use));
                else
                    send_tick(live_rate(), pick_time(TIME_UNDER_EDGE), 1'b1);
                send_tick(live_rate(), pick_time(TIME_MID), 1'b0);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset register values
        send_tick(16'h0000, 20'd5000, 1'b1);
        send_tick(16'hFFFF, 20'd0, 1'b0);
        send_tick(16'd1, 20'hFFFFF, 1'b0);
        send_tick(16'd800, 20'd0, 1'b1);
        send_tick(16'd800, 20'd100, 1'b1);
        send_tick(16'd2500, pick_time(TIME_OVER_EDGE), 1'b1);
        send_tick(16'd2500, pick_time(TIME_UNDER_EDGE), 1'b1);
        send_tick(16'd2500, pick_time(TIME_HEALTHY_EDGE), 1'b0);
        send_tick(16'd2500, pick_time(TIME_MID), 1'b0);
        run_streak(TIME_OVER, 1'b0, 10);
        send_tick(16'h0000, 20'hFFFFF, 1'b1);
        send_tick(16'h8000, pick_time(TIME_HEALTHY), 1'b1);
        send_tick(16'h7FFF, pick_time(TIME_HEALTHY), 1'b1);

        write_all(64'd1, 64'd2, 64'd1, 64'd144, 64'd8,
                  {$urandom, $urandom}, {$urandom, $urandom});
        run_random(150);

        write_all(64'd90, 64'd3, 64'd1, 64'd24, 64'd4,
                  {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        run_random(150);

        // every register but the second rung word all ones: clamps, saturated rung count, widest window
        write_all('1, '1, '1, '1, '1, '1, {$urandom, $urandom});
        run_streak(TIME_OVER, 1'b0, 121);
        run_random(60);

        // every register but the second rung word zero: lowest clamps, then no rungs in use
        write_all('0, '0, '0, '0, '0, '0, {$urandom, $urandom});
        run_random(20);

        // single rung: counters saturate with no step possible
        write_reg(REG_RUNG_COUNT, 64'd1);
        run_streak(TIME_OVER, 1'b0, 265);
        run_streak(TIME_HEALTHY, 1'b1, 265);

        write_reg(REG_OVERLOAD_WIN, 64'd4);
        write_reg(REG_RUNG_COUNT, 64'd5);
        run_random(100);

        wait_idle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("bitrate_ladder_controller_core verification clean");
        else
            $display("bitrate_ladder_controller_core verification failed");
        $finish;
    end

endmodule
